// ----- sv/priority_lock_arbiter_unit_defines.svh -----
// Assertion macros for the priority lock arbiter checkers.
`ifndef PRIORITY_LOCK_ARBITER_UNIT_DEFINES_SVH
`define PRIORITY_LOCK_ARBITER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PLA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PLA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/pla_pkg.sv -----
// Shared constants, status codes and control types for the priority lock arbiter.
package pla_pkg;

	localparam int QUEUE_DEPTH   = 16;
	localparam int PRIORITY_BITS = 8;

	localparam int IDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int COUNT_W    = $clog2(QUEUE_DEPTH + 1);
	localparam int PRIO_W     = PRIORITY_BITS;
	localparam int REQ_W      = 6;
	localparam int PRIO_IN_W  = 8;
	localparam int STATUS_W   = 3;
	localparam int WCOUNT_W   = 5;

	typedef enum logic [STATUS_W-1:0] {
		ST_GRANTED = 3'd0,
		ST_QUEUED  = 3'd1,
		ST_HANDED  = 3'd2,
		ST_FREED   = 3'd3,
		ST_FULL    = 3'd4
	} status_t;

	typedef struct packed {
		logic latch;
		logic acq;
		logic scan_step;
		logic rel;
	} pla_cmd_t;

	typedef struct packed {
		logic rel_in;
		logic scan_last;
	} pla_sts_t;

endpackage

// ----- sv/pla_ctrl.sv -----
// Controller state machine: sequences accept, acquire, scan, release and output load.
module pla_ctrl import pla_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  pla_sts_t sts,
	output pla_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_ACQ,
		S_SCAN,
		S_REL
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;
	logic   out_load;

	assign out_free  = !out_valid_q || out_ready;
	assign out_load  = cmd.acq || cmd.rel;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: cmd.latch     = in_valid;
			S_ACQ:  cmd.acq       = out_free;
			S_SCAN: cmd.scan_step = 1'b1;
			S_REL:  cmd.rel       = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q) inside
				S_IDLE: begin
					if (in_valid)
						state_q <= sts.rel_in ? S_SCAN : S_ACQ;
				end
				S_ACQ, S_REL: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				S_SCAN: begin
					if (sts.scan_last)
						state_q <= S_REL;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- sv/pla_dp.sv -----
// Datapath: lock flag, waiter store, release scan registers and output registers.
module pla_dp import pla_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pla_cmd_t             cmd,
	output pla_sts_t             sts,
	input  logic                 mode,
	input  logic [REQ_W-1:0]     requester,
	input  logic [PRIO_IN_W-1:0] priority_req,
	output logic [STATUS_W-1:0]  status,
	output logic [REQ_W-1:0]     woken_requester,
	output logic [WCOUNT_W-1:0]  waiter_count
);

	logic                lock_q;
	logic                valid_q [QUEUE_DEPTH];
	logic [REQ_W-1:0]    id_q    [QUEUE_DEPTH];
	logic [PRIO_W-1:0]   pr_q    [QUEUE_DEPTH];
	logic [IDX_W-1:0]    age_q   [QUEUE_DEPTH];
	logic [COUNT_W-1:0]  count_q;

	logic [REQ_W-1:0]    req_q;
	logic [PRIO_W-1:0]   prio_q;

	logic [IDX_W-1:0]    idx_q;
	logic                found_q;
	logic [IDX_W-1:0]    best_q;
	logic [PRIO_W-1:0]   best_pr_q;
	logic [IDX_W-1:0]    best_age_q;

	status_t             status_q;
	logic [REQ_W-1:0]    woken_q;
	logic [WCOUNT_W-1:0] wcount_q;

	logic [IDX_W-1:0]    free_idx;
	logic                full;
	logic                cand;

	always_comb begin
		free_idx = '0;
		for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
			if (!valid_q[i])
				free_idx = IDX_W'(i);
	end

	assign full = (count_q == COUNT_W'(QUEUE_DEPTH));

	assign cand = valid_q[idx_q] &&
		(!found_q || (pr_q[idx_q] > best_pr_q) ||
		 ((pr_q[idx_q] == best_pr_q) && (age_q[idx_q] > best_age_q)));

	assign sts.rel_in    = mode;
	assign sts.scan_last = (idx_q == IDX_W'(QUEUE_DEPTH - 1));

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_q  <= 1'b0;
			count_q <= '0;
			found_q <= 1'b0;
			idx_q   <= '0;
			for (int i = 0; i < QUEUE_DEPTH; i++)
				valid_q[i] <= 1'b0;
		end else begin
			if (cmd.latch) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end
			if (cmd.scan_step) begin
				idx_q <= idx_q + IDX_W'(1);
				if (cand)
					found_q <= 1'b1;
			end
			if (cmd.acq) begin
				if (!lock_q) begin
					lock_q <= 1'b1;
				end else if (!full) begin
					valid_q[free_idx] <= 1'b1;
					count_q           <= count_q + COUNT_W'(1);
				end
			end
			if (cmd.rel) begin
				if (!found_q) begin
					lock_q <= 1'b0;
				end else begin
					lock_q          <= 1'b1;
					valid_q[best_q] <= 1'b0;
					count_q         <= count_q - COUNT_W'(1);
				end
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q  <= requester;
			prio_q <= PRIO_W'(priority_req);
		end
		if (cmd.scan_step && cand) begin
			best_q     <= idx_q;
			best_pr_q  <= pr_q[idx_q];
			best_age_q <= age_q[idx_q];
		end
		if (cmd.acq) begin
			woken_q <= '0;
			if (!lock_q) begin
				status_q <= ST_GRANTED;
				wcount_q <= WCOUNT_W'(count_q);
			end else if (full) begin
				status_q <= ST_FULL;
				wcount_q <= WCOUNT_W'(count_q);
			end else begin
				id_q[free_idx]  <= req_q;
				pr_q[free_idx]  <= prio_q;
				age_q[free_idx] <= IDX_W'(count_q);
				status_q        <= ST_QUEUED;
				wcount_q        <= WCOUNT_W'(count_q + COUNT_W'(1));
			end
		end
		if (cmd.rel) begin
			if (!found_q) begin
				status_q <= ST_FREED;
				woken_q  <= '0;
				wcount_q <= WCOUNT_W'(count_q);
			end else begin
				for (int i = 0; i < QUEUE_DEPTH; i++)
					if (valid_q[i] && (age_q[i] > best_age_q))
						age_q[i] <= age_q[i] - IDX_W'(1);
				status_q <= ST_HANDED;
				woken_q  <= id_q[best_q];
				wcount_q <= WCOUNT_W'(count_q - COUNT_W'(1));
			end
		end
	end

	assign status          = status_q;
	assign woken_requester = woken_q;
	assign waiter_count    = wcount_q;

endmodule

// ----- sv/priority_lock_arbiter_unit.sv -----
// Priority lock arbiter: one transaction in, one status transaction out. An acquire
// (mode 0) takes a free lock or joins the waiter store; a release (mode 1) hands the lock
// to the highest-priority waiter, newest first on ties, or frees it when nobody waits.
// Items are handled one at a time. After the accept, an acquire result is loaded in the
// acquire state; a release result is loaded in the release state, after the release scan
// that reads one waiter entry per cycle. The result sits in an output register, so the
// next transaction is accepted the cycle after a result is loaded, even while it waits for
// out_ready. The following result then waits for that register to empty.
module priority_lock_arbiter_unit import pla_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 mode,
	input  logic [REQ_W-1:0]     requester,
	input  logic [PRIO_IN_W-1:0] priority_req,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [STATUS_W-1:0]  status,
	output logic [REQ_W-1:0]     woken_requester,
	output logic [WCOUNT_W-1:0]  waiter_count
);

	pla_cmd_t cmd;
	pla_sts_t sts;

	pla_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pla_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.mode            (mode),
		.requester       (requester),
		.priority_req    (priority_req),
		.status          (status),
		.woken_requester (woken_requester),
		.waiter_count    (waiter_count)
	);

endmodule

// ----- sv/pla_checker.sv -----
// Port-level checker for the priority lock arbiter, bound to the top level.
`include "priority_lock_arbiter_unit_defines.svh"

module pla_checker import pla_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 mode,
	input logic [REQ_W-1:0]     requester,
	input logic [PRIO_IN_W-1:0] priority_req,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [STATUS_W-1:0]  status,
	input logic [REQ_W-1:0]     woken_requester,
	input logic [WCOUNT_W-1:0]  waiter_count
);

	`PLA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(woken_requester) && $stable(waiter_count), "stalled result changed")
	`PLA_ASSERT_NOW(a_woken_zero, out_valid && (status != ST_HANDED), woken_requester == '0, "woken id set without handoff")
	`PLA_ASSERT_NOW(a_full_count, out_valid && (status == ST_FULL), waiter_count == WCOUNT_W'(QUEUE_DEPTH), "reject with store not full")
	`PLA_ASSERT_NOW(a_freed_empty, out_valid && (status == ST_FREED), waiter_count == '0, "lock freed with waiters left")

endmodule

bind priority_lock_arbiter_unit pla_checker u_pla_checker (.*);
